// ===== rtl/core/ctc3d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc3d_pkg
// Shared widths, request and register codes, and types for the three-way
// contingency table counter.
// ----------------------------------------------------------------------------
package ctc3d_pkg;

  localparam int LEVEL_W    = 5;
  localparam int REQ_W      = 2;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int LVL_CMP_W  = 9;
  localparam int OP_W       = 2;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_LEVELS = 2'd2;

  localparam logic [LEVEL_W-1:0] X_COUNT_RST = 5'd16;
  localparam logic [LEVEL_W-1:0] Y_COUNT_RST = 5'd16;
  localparam logic [LEVEL_W-1:0] Z_COUNT_RST = 5'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_SWEEP  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_UPDATE = 2'd2
  } back_state_e;

endpackage

// ===== rtl/core/ctc3d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc3d_front
// Holds the level count registers, accepts request transactions, checks the
// levels against the configured range and pushes a classified command.
// ----------------------------------------------------------------------------
module ctc3d_front
  import ctc3d_pkg::*;
#(
  parameter int MAX_X_LEVELS = 16,
  parameter int MAX_Y_LEVELS = 16,
  parameter int MAX_Z_LEVELS = 16,
  parameter int CMD_W        = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [LEVEL_W-1:0]   x_level_i,
  input  logic [LEVEL_W-1:0]   y_level_i,
  input  logic [LEVEL_W-1:0]   z_level_i,
  input  logic                 q_ready_i,
  input  logic                 init_busy_i,
  output logic                 push_o,
  output logic [CMD_W-1:0]     cmd_o
);

  localparam int XW = (MAX_X_LEVELS > 1) ? $clog2(MAX_X_LEVELS) : 1;
  localparam int YW = (MAX_Y_LEVELS > 1) ? $clog2(MAX_Y_LEVELS) : 1;
  localparam int ZW = (MAX_Z_LEVELS > 1) ? $clog2(MAX_Z_LEVELS) : 1;
  localparam logic [LVL_CMP_W-1:0] X_LIM = LVL_CMP_W'(MAX_X_LEVELS);
  localparam logic [LVL_CMP_W-1:0] Y_LIM = LVL_CMP_W'(MAX_Y_LEVELS);
  localparam logic [LVL_CMP_W-1:0] Z_LIM = LVL_CMP_W'(MAX_Z_LEVELS);

  logic [LEVEL_W-1:0] x_count_q, y_count_q, z_count_q;
  logic               levels_ok;
  op_e                op;
  logic [XW-1:0]      x_idx;
  logic [YW-1:0]      y_idx;
  logic [ZW-1:0]      z_idx;

  function automatic logic level_ok(input logic [LEVEL_W-1:0]   lvl,
                                    input logic [LEVEL_W-1:0]   used,
                                    input logic [LVL_CMP_W-1:0] lim);
    return (lvl != '0) && (lvl <= used) && (LVL_CMP_W'(lvl) <= lim);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_count_q <= X_COUNT_RST;
      y_count_q <= Y_COUNT_RST;
      z_count_q <= Z_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_LEVELS: x_count_q <= cfg_wdata_i;
        CFG_Y_LEVELS: y_count_q <= cfg_wdata_i;
        CFG_Z_LEVELS: z_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign levels_ok = level_ok(x_level_i, x_count_q, X_LIM) &&
                     level_ok(y_level_i, y_count_q, Y_LIM) &&
                     level_ok(z_level_i, z_count_q, Z_LIM);

  always_comb begin
    unique case (req_type_i) inside
      REQ_ADD:             op = levels_ok ? OP_ADD : OP_REJECT;
      REQ_CLEAR:           op = OP_CLEAR;
      REQ_READ, REQ_SPARE: op = levels_ok ? OP_READ : OP_REJECT;
      default:             op = OP_READ;
    endcase
  end

  // Levels are 1-based; in-range levels always fit the index width.
  assign x_idx = XW'(x_level_i - LEVEL_W'(1));
  assign y_idx = YW'(y_level_i - LEVEL_W'(1));
  assign z_idx = ZW'(z_level_i - LEVEL_W'(1));

  assign in_ready_o = q_ready_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign cmd_o      = {op, z_idx, x_idx, y_idx};

endmodule

// ===== rtl/core/ctc3d_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc3d_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ctc3d_queue #(
  parameter int W = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         ready_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         pop_i
);

  localparam logic [1:0] CNT_FULL = 2'd2;

  logic [W-1:0] ent_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign ready_o = (cnt_q != CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/ctc3d_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc3d_back
// Executes queued commands on the count memories: registered read, then a
// saturating update and result load once the output is free; sweeps on clear.
// ----------------------------------------------------------------------------
module ctc3d_back
  import ctc3d_pkg::*;
#(
  parameter int MAX_X_LEVELS = 16,
  parameter int MAX_Y_LEVELS = 16,
  parameter int MAX_Z_LEVELS = 16,
  parameter int COUNT_WIDTH  = 32,
  parameter int CMD_W        = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [CMD_W-1:0] q_data_i,
  output logic             pop_o,
  output logic             init_busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [OUT_W-1:0] joint_count_o,
  output logic [OUT_W-1:0] row_marginal_o,
  output logic [OUT_W-1:0] col_marginal_o,
  output logic [OUT_W-1:0] layer_total_o,
  output logic [OUT_W-1:0] total_count_o
);

  localparam int XW = (MAX_X_LEVELS > 1) ? $clog2(MAX_X_LEVELS) : 1;
  localparam int YW = (MAX_Y_LEVELS > 1) ? $clog2(MAX_Y_LEVELS) : 1;
  localparam int ZW = (MAX_Z_LEVELS > 1) ? $clog2(MAX_Z_LEVELS) : 1;
  localparam int JW = ZW + XW + YW;
  localparam int RW = ZW + XW;
  localparam int CW = ZW + YW;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  back_state_e state_q, state_d;
  logic [JW-1:0] sweep_q;
  logic          reply_q;
  cnt_t          total_q;
  logic          out_valid_q;

  op_e           head_op, cur_op_q;
  logic [ZW-1:0] head_z, cur_z_q;
  logic [XW-1:0] head_x, cur_x_q;
  logic [YW-1:0] head_y, cur_y_q;

  cnt_t joint_mem [2**JW];
  cnt_t row_mem   [2**RW];
  cnt_t col_mem   [2**CW];
  cnt_t layer_mem [2**ZW];
  cnt_t joint_rd_q, row_rd_q, col_rd_q, layer_rd_q;
  cnt_t joint_inc, row_inc, col_inc, layer_inc, total_inc;

  logic          mem_re, mem_we, sweeping, load_out;
  logic [JW-1:0] j_waddr;
  logic [RW-1:0] r_waddr;
  logic [CW-1:0] c_waddr;
  logic [ZW-1:0] l_waddr;
  cnt_t          j_wdata, r_wdata, c_wdata, l_wdata;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  assign head_op = op_e'(q_data_i[CMD_W-1 -: OP_W]);
  assign head_z  = q_data_i[XW+YW +: ZW];
  assign head_x  = q_data_i[YW +: XW];
  assign head_y  = q_data_i[0 +: YW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    mem_re   = 1'b0;
    sweeping = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        sweeping = 1'b1;
        if (&sweep_q) begin
          state_d = reply_q ? ST_UPDATE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          mem_re  = (head_op != OP_CLEAR);
          state_d = (head_op == OP_CLEAR) ? ST_SWEEP : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign joint_inc = sat_inc(joint_rd_q);
  assign row_inc   = sat_inc(row_rd_q);
  assign col_inc   = sat_inc(col_rd_q);
  assign layer_inc = sat_inc(layer_rd_q);
  assign total_inc = sat_inc(total_q);

  assign mem_we  = sweeping || (load_out && (cur_op_q == OP_ADD));
  assign j_waddr = sweeping ? sweep_q : {cur_z_q, cur_x_q, cur_y_q};
  assign r_waddr = sweeping ? sweep_q[RW-1:0] : {cur_z_q, cur_x_q};
  assign c_waddr = sweeping ? sweep_q[CW-1:0] : {cur_z_q, cur_y_q};
  assign l_waddr = sweeping ? sweep_q[ZW-1:0] : cur_z_q;
  assign j_wdata = sweeping ? '0 : joint_inc;
  assign r_wdata = sweeping ? '0 : row_inc;
  assign c_wdata = sweeping ? '0 : col_inc;
  assign l_wdata = sweeping ? '0 : layer_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      joint_mem[j_waddr] <= j_wdata;
    end
    if (mem_re) begin
      joint_rd_q <= joint_mem[{head_z, head_x, head_y}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[r_waddr] <= r_wdata;
    end
    if (mem_re) begin
      row_rd_q <= row_mem[{head_z, head_x}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      col_mem[c_waddr] <= c_wdata;
    end
    if (mem_re) begin
      col_rd_q <= col_mem[{head_z, head_y}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      layer_mem[l_waddr] <= l_wdata;
    end
    if (mem_re) begin
      layer_rd_q <= layer_mem[head_z];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_op_q <= head_op;
      cur_z_q  <= head_z;
      cur_x_q  <= head_x;
      cur_y_q  <= head_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      reply_q     <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (sweeping) begin
        sweep_q <= sweep_q + JW'(1);
        total_q <= '0;
        if (&sweep_q) begin
          reply_q <= 1'b0;
        end
      end
      if (pop_o && (head_op == OP_CLEAR)) begin
        reply_q <= 1'b1;
      end
      if (load_out && (cur_op_q == OP_ADD)) begin
        total_q <= total_inc;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      unique case (cur_op_q)
        OP_ADD: begin
          status_o       <= 1'b0;
          joint_count_o  <= OUT_W'(joint_inc);
          row_marginal_o <= OUT_W'(row_inc);
          col_marginal_o <= OUT_W'(col_inc);
          layer_total_o  <= OUT_W'(layer_inc);
          total_count_o  <= OUT_W'(total_inc);
        end
        OP_READ: begin
          status_o       <= 1'b0;
          joint_count_o  <= OUT_W'(joint_rd_q);
          row_marginal_o <= OUT_W'(row_rd_q);
          col_marginal_o <= OUT_W'(col_rd_q);
          layer_total_o  <= OUT_W'(layer_rd_q);
          total_count_o  <= OUT_W'(total_q);
        end
        OP_CLEAR: begin
          status_o       <= 1'b0;
          joint_count_o  <= '0;
          row_marginal_o <= '0;
          col_marginal_o <= '0;
          layer_total_o  <= '0;
          total_count_o  <= '0;
        end
        OP_REJECT: begin
          status_o       <= 1'b1;
          joint_count_o  <= '0;
          row_marginal_o <= '0;
          col_marginal_o <= '0;
          layer_total_o  <= '0;
          total_count_o  <= OUT_W'(total_q);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign init_busy_o = (state_q == ST_SWEEP) && !reply_q;

endmodule

// ===== rtl/core/contingency_table_3d_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contingency_table_3d_counter
// Three-way contingency table with joint counts, row and column marginals
// per layer, layer totals and an overall observation total.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o: add, read or clear with 1-based
//   x, y and z levels. Each transaction yields exactly one result on
//   out_valid_o/out_ready_i, in request order. The user must write level
//   counts on the cfg_* port only while the block is idle; it is not enforced.
//   Add and read each pass through the execution unit as a memory read, then
//   saturating update and write-back; it pops no new request until the last
//   one has loaded its result, and waits while the result register is full.
//   A clear sweeps every count memory, one address per cycle, over all
//   2**(clog2(MAX_Z)+clog2(MAX_X)+clog2(MAX_Y)) joint addresses (4096 by
//   default); its result follows the sweep. Requests queue behind it.
//   After reset the same sweep runs with in_ready_o low, and no result.
//   A stalled receiver holds the result register; a two-entry command queue
//   keeps accepting until it fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module contingency_table_3d_counter
  import ctc3d_pkg::*;
#(
  parameter int MAX_X_LEVELS = 16,
  parameter int MAX_Y_LEVELS = 16,
  parameter int MAX_Z_LEVELS = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [LEVEL_W-1:0]   x_level_i,
  input  logic [LEVEL_W-1:0]   y_level_i,
  input  logic [LEVEL_W-1:0]   z_level_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 status_o,
  output logic [OUT_W-1:0]     joint_count_o,
  output logic [OUT_W-1:0]     row_marginal_o,
  output logic [OUT_W-1:0]     col_marginal_o,
  output logic [OUT_W-1:0]     layer_total_o,
  output logic [OUT_W-1:0]     total_count_o
);

  localparam int XW    = (MAX_X_LEVELS > 1) ? $clog2(MAX_X_LEVELS) : 1;
  localparam int YW    = (MAX_Y_LEVELS > 1) ? $clog2(MAX_Y_LEVELS) : 1;
  localparam int ZW    = (MAX_Z_LEVELS > 1) ? $clog2(MAX_Z_LEVELS) : 1;
  localparam int CMD_W = OP_W + ZW + XW + YW;

  logic             push, q_ready, q_valid, pop, init_busy;
  logic [CMD_W-1:0] cmd, q_data;

  ctc3d_front #(
    .MAX_X_LEVELS(MAX_X_LEVELS),
    .MAX_Y_LEVELS(MAX_Y_LEVELS),
    .MAX_Z_LEVELS(MAX_Z_LEVELS),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .x_level_i  (x_level_i),
    .y_level_i  (y_level_i),
    .z_level_i  (z_level_i),
    .q_ready_i  (q_ready),
    .init_busy_i(init_busy),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  ctc3d_queue #(
    .W(CMD_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .data_o (q_data),
    .pop_i  (pop)
  );

  ctc3d_back #(
    .MAX_X_LEVELS(MAX_X_LEVELS),
    .MAX_Y_LEVELS(MAX_Y_LEVELS),
    .MAX_Z_LEVELS(MAX_Z_LEVELS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .pop_o         (pop),
    .init_busy_o   (init_busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .joint_count_o (joint_count_o),
    .row_marginal_o(row_marginal_o),
    .col_marginal_o(col_marginal_o),
    .layer_total_o (layer_total_o),
    .total_count_o (total_count_o)
  );

endmodule

// ===== rtl/core/ctc3d_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc3d_check
// Port-level checks for the contingency table counter, bound to the top.
// ----------------------------------------------------------------------------
module ctc3d_check
  import ctc3d_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [LEVEL_W-1:0]   cfg_wdata_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [REQ_W-1:0]     req_type_i,
  input logic [LEVEL_W-1:0]   x_level_i,
  input logic [LEVEL_W-1:0]   y_level_i,
  input logic [LEVEL_W-1:0]   z_level_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 status_o,
  input logic [OUT_W-1:0]     joint_count_o,
  input logic [OUT_W-1:0]     row_marginal_o,
  input logic [OUT_W-1:0]     col_marginal_o,
  input logic [OUT_W-1:0]     layer_total_o,
  input logic [OUT_W-1:0]     total_count_o
);

  localparam logic NARROW = (COUNT_WIDTH <= OUT_W);

  // A waiting result keeps its status and counts.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(joint_count_o) && $stable(total_count_o))
    else $error("result changed while stalled");

  // A rejected request reports no cell counts.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> joint_count_o == '0 && row_marginal_o == '0 &&
      col_marginal_o == '0 && layer_total_o == '0)
    else $error("rejected request carries counts");

  // Marginals dominate the joint cell, layer totals dominate marginals, the total dominates layer totals.
  a_marginals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o && NARROW |->
      joint_count_o <= row_marginal_o && joint_count_o <= col_marginal_o &&
      row_marginal_o <= layer_total_o && col_marginal_o <= layer_total_o &&
      layer_total_o <= total_count_o)
    else $error("marginals inconsistent with joint count");

  // The memories are swept right after reset, so no request is taken.
  a_init_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("request accepted during reset sweep");

endmodule

bind contingency_table_3d_counter ctc3d_check #(.COUNT_WIDTH(COUNT_WIDTH)) u_check (.*);

// ===== sim/contingency_table_3d_counter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contingency_table_3d_counter_checker
// Watches the level-count, request and result ports of the contingency table
// counter. Keeps shadow joint, marginal and total counts, works out the
// result of every accepted request and compares the results in order.
// ----------------------------------------------------------------------------
module contingency_table_3d_counter_checker
  import ctc3d_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [LEVEL_W-1:0]   x_level_i,
  input  logic [LEVEL_W-1:0]   y_level_i,
  input  logic [LEVEL_W-1:0]   z_level_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 status_i,
  input  logic [OUT_W-1:0]     joint_count_i,
  input  logic [OUT_W-1:0]     row_marginal_i,
  input  logic [OUT_W-1:0]     col_marginal_i,
  input  logic [OUT_W-1:0]     layer_total_i,
  input  logic [OUT_W-1:0]     total_count_i,
  output int                   pending_o,
  output int                   fail_count_o,
  output int                   checked_o,
  output int                   rejected_o
);

  localparam int NX          = 16;
  localparam int NY          = 16;
  localparam int NZ          = 16;
  localparam int CNT_W       = 32;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] joint;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] layer;
    logic [OUT_W-1:0] total;
  } cell_report_t;

  logic [CNT_W-1:0]   joint_tab [NZ][NX][NY];
  logic [CNT_W-1:0]   row_tab   [NZ][NX];
  logic [CNT_W-1:0]   col_tab   [NZ][NY];
  logic [CNT_W-1:0]   layer_tab [NZ];
  logic [CNT_W-1:0]   obs_total;
  logic [LEVEL_W-1:0] x_used = X_COUNT_RST;
  logic [LEVEL_W-1:0] y_used = Y_COUNT_RST;
  logic [LEVEL_W-1:0] z_used = Z_COUNT_RST;

  cell_report_t cell_reports_q[$];
  int pending  = 0;
  int fails    = 0;
  int checked  = 0;
  int rejected = 0;

  assign pending_o    = pending;
  assign fail_count_o = fails;
  assign checked_o    = checked;
  assign rejected_o   = rejected;

  // Hold at the top value instead of wrapping.
  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic bit in_range(logic [LEVEL_W-1:0] lvl, logic [LEVEL_W-1:0] used,
                                  int lim);
    return (lvl >= 1) && (lvl <= used) && (int'(lvl) <= lim);
  endfunction

  task automatic wipe_tables();
    for (int z = 0; z < NZ; z++) begin
      layer_tab[z] = '0;
      for (int x = 0; x < NX; x++) begin
        row_tab[z][x] = '0;
        for (int y = 0; y < NY; y++) joint_tab[z][x][y] = '0;
      end
      for (int y = 0; y < NY; y++) col_tab[z][y] = '0;
    end
    obs_total = '0;
  endtask

  task automatic tally_request(logic [REQ_W-1:0] req, logic [LEVEL_W-1:0] xl,
                               logic [LEVEL_W-1:0] yl, logic [LEVEL_W-1:0] zl);
    cell_report_t rep;
    int xi;
    int yi;
    int zi;
    rep = '0;
    if (req == REQ_CLEAR) begin
      wipe_tables();
    end else if (!in_range(xl, x_used, NX) || !in_range(yl, y_used, NY) ||
                 !in_range(zl, z_used, NZ)) begin
      // Drop the request; only the overall total is reported.
      rep.status = 1'b1;
      rep.total  = obs_total;
      rejected++;
    end else begin
      xi = int'(xl) - 1;
      yi = int'(yl) - 1;
      zi = int'(zl) - 1;
      if (req == REQ_ADD) begin
        joint_tab[zi][xi][yi] = bump(joint_tab[zi][xi][yi]);
        row_tab[zi][xi]       = bump(row_tab[zi][xi]);
        col_tab[zi][yi]       = bump(col_tab[zi][yi]);
        layer_tab[zi]         = bump(layer_tab[zi]);
        obs_total             = bump(obs_total);
      end
      rep.joint = joint_tab[zi][xi][yi];
      rep.row   = row_tab[zi][xi];
      rep.col   = col_tab[zi][yi];
      rep.layer = layer_tab[zi];
      rep.total = obs_total;
    end
    cell_reports_q.push_back(rep);
  endtask

  task automatic compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_report_t want;
    if (!rst_ni) begin
      wipe_tables();
      x_used = X_COUNT_RST;
      y_used = Y_COUNT_RST;
      z_used = Z_COUNT_RST;
      cell_reports_q.delete();
    end else begin
      // Check before pushing so a same-edge request never matches an older result.
      if (out_valid_i && out_ready_i) begin
        if (cell_reports_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t ns: unexpected result, expected none, got total %0d",
                     $time, total_count_i);
        end else begin
          want = cell_reports_q.pop_front();
          checked++;
          compare_field("status", OUT_W'(want.status), OUT_W'(status_i));
          compare_field("joint_count", want.joint, joint_count_i);
          compare_field("row_marginal", want.row, row_marginal_i);
          compare_field("col_marginal", want.col, col_marginal_i);
          compare_field("layer_total", want.layer, layer_total_i);
          compare_field("total_count", want.total, total_count_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_X_LEVELS: x_used = cfg_wdata_i;
          CFG_Y_LEVELS: y_used = cfg_wdata_i;
          CFG_Z_LEVELS: z_used = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        tally_request(req_type_i, x_level_i, y_level_i, z_level_i);
    end
    pending = cell_reports_q.size();
  end

endmodule

// ===== sim/contingency_table_3d_counter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contingency_table_3d_counter_test
// Drives add, read and clear requests into the contingency table counter
// under a series of level-count settings, with random gaps and stalls on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module contingency_table_3d_counter_test;
  import ctc3d_pkg::*;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx     = CFG_X_LEVELS;
  logic [LEVEL_W-1:0]   cfg_wdata   = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [REQ_W-1:0]     req_type    = REQ_ADD;
  logic [LEVEL_W-1:0]   x_level     = '0;
  logic [LEVEL_W-1:0]   y_level     = '0;
  logic [LEVEL_W-1:0]   z_level     = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic                 status;
  logic [OUT_W-1:0]     joint_count;
  logic [OUT_W-1:0]     row_marginal;
  logic [OUT_W-1:0]     col_marginal;
  logic [OUT_W-1:0]     layer_total;
  logic [OUT_W-1:0]     total_count;

  int pending;
  int fail_count;
  int checked;
  int rejected;

  logic [LEVEL_W-1:0] x_cnt = X_COUNT_RST;
  logic [LEVEL_W-1:0] y_cnt = Y_COUNT_RST;
  logic [LEVEL_W-1:0] z_cnt = Z_COUNT_RST;

  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;
  int clears_left  = 6;
  int n_add        = 0;
  int n_read       = 0;
  int n_clear      = 0;
  int n_settings   = 0;

  contingency_table_3d_counter dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .x_level_i      (x_level),
    .y_level_i      (y_level),
    .z_level_i      (z_level),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .joint_count_o  (joint_count),
    .row_marginal_o (row_marginal),
    .col_marginal_o (col_marginal),
    .layer_total_o  (layer_total),
    .total_count_o  (total_count)
  );

  contingency_table_3d_counter_checker tally_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .x_level_i      (x_level),
    .y_level_i      (y_level),
    .z_level_i      (z_level),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .joint_count_i  (joint_count),
    .row_marginal_i (row_marginal),
    .col_marginal_i (col_marginal),
    .layer_total_i  (layer_total),
    .total_count_i  (total_count),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .checked_o      (checked),
    .rejected_o     (rejected)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Run timed out at %0t ns with %0d results outstanding", $time, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap(int short_max, int long_lo, int long_hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 93) return $urandom_range(1, short_max);
    return $urandom_range(long_lo, long_hi);
  endfunction

  // Favor a few low levels so the counts build up; mix in raw 5-bit noise.
  function automatic logic [LEVEL_W-1:0] pick_level(logic [LEVEL_W-1:0] used);
    int unsigned eff;
    int unsigned r;
    eff = (used > 16) ? 16 : used;
    r   = $urandom_range(0, 99);
    if (eff == 0 || r < 8) return LEVEL_W'($urandom_range(0, 31));
    if (r < 50) return LEVEL_W'($urandom_range(1, (eff < 3) ? eff : 3));
    return LEVEL_W'($urandom_range(1, eff));
  endfunction

  function automatic logic [REQ_W-1:0] pick_req();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r < 2 && clears_left > 0) begin
      clears_left--;
      return REQ_CLEAR;
    end
    if (r < 120) return REQ_ADD;
    if (r < 185) return REQ_READ;
    return REQ_SPARE;
  endfunction

  // Offer one request, hold it until accepted, then maybe idle.
  task automatic issue(logic [REQ_W-1:0] req, logic [LEVEL_W-1:0] xl,
                       logic [LEVEL_W-1:0] yl, logic [LEVEL_W-1:0] zl);
    int gap;
    in_valid <= 1'b1;
    req_type <= req;
    x_level  <= xl;
    y_level  <= yl;
    z_level  <= zl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (req)
      REQ_ADD:   n_add++;
      REQ_CLEAR: n_clear++;
      default:   n_read++;
    endcase
    gap = pick_gap(3, 8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_levels(logic [LEVEL_W-1:0] xc, logic [LEVEL_W-1:0] yc,
                              logic [LEVEL_W-1:0] zc);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_X_LEVELS;
    cfg_wdata <= xc;
    @(posedge clk);
    cfg_idx   <= CFG_Y_LEVELS;
    cfg_wdata <= yc;
    @(posedge clk);
    cfg_idx   <= CFG_Z_LEVELS;
    cfg_wdata <= zc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    x_cnt = xc;
    y_cnt = yc;
    z_cnt = zc;
    n_settings++;
  endtask

  initial begin : receiver
    int stall;
    int unsigned r;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = 120;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!no_idle && r < 25) stall = $urandom_range(1, 3);
        else if (!no_idle && r < 28) stall = $urandom_range(10, 40);
      end
    end
  end

  initial begin : stimulus
    int n_items;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset levels: 16 x 16 with a single layer.
    issue(REQ_ADD,   5'd1,  5'd1,  5'd1);
    issue(REQ_ADD,   5'd16, 5'd16, 5'd1);
    issue(REQ_ADD,   5'd16, 5'd16, 5'd1);
    issue(REQ_ADD,   5'd16, 5'd1,  5'd1);
    issue(REQ_READ,  5'd16, 5'd16, 5'd1);
    issue(REQ_SPARE, 5'd16, 5'd1,  5'd1);
    issue(REQ_ADD,   5'd0,  5'd1,  5'd1);
    issue(REQ_ADD,   5'd17, 5'd1,  5'd1);
    issue(REQ_READ,  5'd1,  5'd31, 5'd1);
    issue(REQ_ADD,   5'd1,  5'd1,  5'd2);
    issue(REQ_READ,  5'd1,  5'd1,  5'd0);
    issue(REQ_CLEAR, 5'd31, 5'd31, 5'd31);
    issue(REQ_READ,  5'd16, 5'd16, 5'd1);
    issue(REQ_ADD,   5'd8,  5'd8,  5'd1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_levels(5'd16, 5'd16, 5'd16);
        1: write_levels(5'd1, 5'd1, 5'd1);
        2: write_levels(5'd0, 5'd5, 5'd3);
        3: write_levels(5'd31, 5'd31, 5'd31);
        4: write_levels(5'd4, 5'd3, 5'd2);
        5: write_levels(LEVEL_W'($urandom_range(1, 16)), LEVEL_W'($urandom_range(1, 16)),
                        LEVEL_W'($urandom_range(1, 16)));
        default: write_levels(LEVEL_W'($urandom_range(0, 31)),
                              LEVEL_W'($urandom_range(0, 31)),
                              LEVEL_W'($urandom_range(0, 31)));
      endcase
      if (ph == 0) begin
        issue(REQ_ADD,  5'd16, 5'd16, 5'd16);
        issue(REQ_ADD,  5'd1,  5'd16, 5'd16);
        issue(REQ_READ, 5'd16, 5'd1,  5'd16);
        issue(REQ_ADD,  5'd16, 5'd16, 5'd17);
        issue(REQ_READ, 5'd16, 5'd16, 5'd16);
        issue(REQ_ADD,  5'd5,  5'd5,  5'd15);
      end
      // Back-to-back requests against a long receiver stall fill the block up.
      no_idle = (ph == 4);
      if (ph == 4) hold_off_req = 1'b1;
      n_items = (ph == 2) ? 20 : 80;
      repeat (n_items) issue(pick_req(), pick_level(x_cnt), pick_level(y_cnt), pick_level(z_cnt));
      drain();
      no_idle = 1'b0;
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d requests: %0d adds, %0d reads, %0d clears, over %0d level settings.",
             n_add + n_read + n_clear, n_add, n_read, n_clear, n_settings);
    $display("Compared %0d results, %0d of them for out-of-range levels.", checked, rejected);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== contingency_table_3d_counter.f =====
rtl/core/ctc3d_pkg.sv
rtl/core/ctc3d_front.sv
rtl/core/ctc3d_queue.sv
rtl/core/ctc3d_back.sv
rtl/core/contingency_table_3d_counter.sv
rtl/core/ctc3d_check.sv
sim/contingency_table_3d_counter_checker.sv
sim/contingency_table_3d_counter_test.sv
